// ===== rtl/core/slt_pkg.sv =====
package slt_pkg;

	localparam int MAX_LEXEME_DEFAULT = 16;
	localparam int KW_COUNT = 9;

	// token classes
	localparam logic [2:0] CLS_OPERATOR   = 3'd0;
	localparam logic [2:0] CLS_SYMBOL     = 3'd1;
	localparam logic [2:0] CLS_NUMBER     = 3'd2;
	localparam logic [2:0] CLS_KEYWORD    = 3'd3;
	localparam logic [2:0] CLS_IDENTIFIER = 3'd4;

	// keyword text, character i at bits [8*i +: 8]
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'h0000_0000_0074_6e69,  // int
		64'h0000_0000_6e69_616d,  // main
		64'h0000_0000_6469_6f76,  // void
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_6573_6c65,  // else
		64'h0000_0000_0000_6f64,  // do
		64'h0000_0065_6c69_6877,  // while
		64'h0000_006b_6165_7262,  // break
		64'h6575_6e69_746e_6f63   // continue
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd4, 4'd4, 4'd2, 4'd4, 4'd2, 4'd5, 4'd5, 4'd8
	};

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_WORD
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FLUSH,
		ST_SINGLE
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [15:0] token_number;
		logic [2:0]  token_class;
		logic [7:0]  lexeme_char;
		logic        token_end;
		logic [15:0] line_number;
		logic        truncated;
		logic        run_last;
	} token_item_t;

	typedef struct packed {
		logic latch;
		logic append;
		logic start_number;
		logic start_word;
		logic line_inc;
		logic emit_flush;
		logic emit_single;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  is_eot;
		logic  is_op;
		logic  is_sym;
		logic  is_nl;
		logic  is_digit;
		logic  is_alpha;
		logic  is_dot;
		logic  flush_last;
		logic  slot_free;
	} sts_t;

endpackage

// ===== rtl/core/simple_lexical_tokenizer.sv =====
// Byte-serial tokenizer.
// Input channel (text_valid / text_stall / text_item): one byte of text per
// item, or an end marker that flushes a pending number or word.
// Output channel (token_valid / token_stall / token_item): one lexeme
// character per item, tagged with token number, class, line number, a
// token_end mark and a run_last mark on the last item caused by an input.
// Sequence: an input item that only extends or starts a lexeme, or is
// skipped, is accepted and then decoded. A single-character operator or
// symbol is then emitted as its own token. A flushed lexeme is emitted one
// character per cycle while the receiver does not stall; unless the flush
// came from the end marker, the ending byte is then decoded again from
// idle, and emitted as well if it is itself a token. The controller
// handles one input item at a time; the buffer read is registered and
// runs one character ahead of the output register.
// Reset: empty buffer, no word pending, token count 0, line 1; no output.
// While the receiver stalls, the output register holds its item and the next
// emit waits; text_stall stays high until the current item is done.
module simple_lexical_tokenizer #(
	parameter int MAX_LEXEME = slt_pkg::MAX_LEXEME_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  slt_pkg::text_item_t  text_item,
	output logic                 token_valid,
	input  logic                 token_stall,
	output slt_pkg::token_item_t token_item
);
	import slt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, decode, then flush / single-token emit
	slt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// lexeme buffer, keyword match, counters and the output register
	slt_datapath #(
		.MAX_LEXEME (MAX_LEXEME)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_item   (text_item),
		.cmd         (cmd),
		.sts         (sts),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

// ===== rtl/core/slt_datapath.sv =====
module slt_datapath #(
	parameter int MAX_LEXEME = slt_pkg::MAX_LEXEME_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slt_pkg::text_item_t text_item,
	input  slt_pkg::cmd_t       cmd,
	output slt_pkg::sts_t       sts,
	output logic                token_valid,
	input  logic                token_stall,
	output slt_pkg::token_item_t token_item
);
	import slt_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEXEME + 1);
	localparam int IDX_W = $clog2(MAX_LEXEME);

	logic [7:0]          byte_q;
	logic                eot_q;
	mode_t               mode_q;
	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic [KW_COUNT-1:0] hit_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_d;
	logic [15:0]         tok_q;
	logic [15:0]         line_q;
	logic [7:0]          rd_data_q;
	logic [7:0]          mem [MAX_LEXEME];
	logic                out_valid_q;
	token_item_t         out_q;

	logic                is_op, is_sym, is_nl, is_digit, is_alpha, is_dot;
	logic                flush_last, slot_free, room, wr_en, kw_match, tok_inc;
	logic [IDX_W-1:0]    wr_addr;
	logic [KW_COUNT-1:0] app_hit, start_hit, len_eq;
	logic [2:0]          flush_cls;

	// byte classes
	always_comb begin
		is_op  = 1'b0;
		is_sym = 1'b0;
		case (byte_q)
			"+", "-", "*", "/", "<", ">", "=": is_op = 1'b1;
			";", "{", "}", "(", ")", "?", "@", "!", "%": is_sym = 1'b1;
			default: ;
		endcase
	end
	assign is_nl    = (byte_q == 8'h0a);
	assign is_digit = (byte_q >= "0") && (byte_q <= "9");
	assign is_alpha = ((byte_q >= "a") && (byte_q <= "z")) ||
	                  ((byte_q >= "A") && (byte_q <= "Z"));
	assign is_dot   = (byte_q == ".");

	assign room       = (len_q < LEN_W'(MAX_LEXEME));
	assign flush_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
	assign slot_free  = !out_valid_q || !token_stall;

	// keyword match kept per keyword as characters arrive
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			app_hit[k] = hit_q[k] && (len_q < LEN_W'(KW_LEN[k])) &&
			             (KW_TEXT[k][{len_q[2:0], 3'b000} +: 8] == byte_q);
			start_hit[k] = (KW_TEXT[k][7:0] == byte_q);
			len_eq[k] = (len_q == LEN_W'(KW_LEN[k]));
		end
	end
	assign kw_match  = !ovf_q && |(hit_q & len_eq);
	assign flush_cls = (mode_q == MODE_NUMBER) ? CLS_NUMBER :
	                   (kw_match ? CLS_KEYWORD : CLS_IDENTIFIER);
	assign tok_inc   = cmd.emit_single || (cmd.emit_flush && flush_last);

	always_comb begin
		idx_d = idx_q;
		if (cmd.emit_flush) begin
			idx_d = flush_last ? '0 : idx_q + IDX_W'(1);
		end
	end

	assign wr_en   = cmd.start_number || cmd.start_word || (cmd.append && room);
	assign wr_addr = (cmd.start_number || cmd.start_word) ? '0 : len_q[IDX_W-1:0];

	// lexeme buffer, read address tracks the emit index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= byte_q;
		end
		rd_data_q <= mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= text_item.text_byte;
			eot_q  <= text_item.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			hit_q  <= '0;
			idx_q  <= '0;
			tok_q  <= '0;
			line_q <= 16'd1;
		end else begin
			idx_q <= idx_d;
			if (cmd.start_number || cmd.start_word) begin
				mode_q <= cmd.start_number ? MODE_NUMBER : MODE_WORD;
				len_q  <= LEN_W'(1);
				ovf_q  <= 1'b0;
				hit_q  <= start_hit;
			end else if (cmd.append) begin
				if (room) begin
					len_q <= len_q + LEN_W'(1);
					hit_q <= app_hit;
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.emit_flush && flush_last) begin
				mode_q <= MODE_IDLE;
				len_q  <= '0;
				ovf_q  <= 1'b0;
			end
			if (tok_inc && (tok_q != 16'hffff)) begin
				tok_q <= tok_q + 16'd1;
			end
			if (cmd.line_inc && (line_q != 16'hffff)) begin
				line_q <= line_q + 16'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_flush || cmd.emit_single) begin
			out_valid_q <= 1'b1;
		end else if (!token_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_flush) begin
			out_q.token_number <= tok_q;
			out_q.token_class  <= flush_cls;
			out_q.lexeme_char  <= rd_data_q;
			out_q.token_end    <= flush_last;
			out_q.line_number  <= line_q;
			out_q.truncated    <= ovf_q;
			out_q.run_last     <= flush_last && (eot_q || !(is_op || is_sym));
		end else if (cmd.emit_single) begin
			out_q.token_number <= tok_q;
			out_q.token_class  <= is_op ? CLS_OPERATOR : CLS_SYMBOL;
			out_q.lexeme_char  <= byte_q;
			out_q.token_end    <= 1'b1;
			out_q.line_number  <= line_q;
			out_q.truncated    <= 1'b0;
			out_q.run_last     <= 1'b1;
		end
	end

	assign token_valid = out_valid_q;
	assign token_item  = out_q;

	always_comb begin
		sts.mode       = mode_q;
		sts.is_eot     = eot_q;
		sts.is_op      = is_op;
		sts.is_sym     = is_sym;
		sts.is_nl      = is_nl;
		sts.is_digit   = is_digit;
		sts.is_alpha   = is_alpha;
		sts.is_dot     = is_dot;
		sts.flush_last = flush_last;
		sts.slot_free  = slot_free;
	end

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_flush || cmd.emit_single) |-> slot_free)
		else $error("emit into an occupied, stalled output slot");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (len_q == '0 && !ovf_q && idx_q == '0))
		else $error("lexeme state left over while idle");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (LEN_W'(idx_q) < len_q))
		else $error("emit index beyond lexeme length");

endmodule

// ===== rtl/core/slt_ctrl.sv =====
module slt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          text_valid,
	output logic          text_stall,
	input  slt_pkg::sts_t sts,
	output slt_pkg::cmd_t cmd
);
	import slt_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		text_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (text_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_eot) begin
					state_d = (sts.mode != MODE_IDLE) ? ST_FLUSH : ST_IDLE;
				end else begin
					case (sts.mode)
						MODE_NUMBER: begin
							if (sts.is_digit || sts.is_dot) begin
								cmd.append = 1'b1;
								state_d    = ST_IDLE;
							end else begin
								state_d = ST_FLUSH;
							end
						end
						MODE_WORD: begin
							if (sts.is_alpha || sts.is_digit || sts.is_dot) begin
								cmd.append = 1'b1;
								state_d    = ST_IDLE;
							end else begin
								state_d = ST_FLUSH;
							end
						end
						default: begin
							state_d = ST_IDLE;
							if (sts.is_op || sts.is_sym) begin
								state_d = ST_SINGLE;
							end else if (sts.is_nl) begin
								cmd.line_inc = 1'b1;
							end else if (sts.is_digit) begin
								cmd.start_number = 1'b1;
							end else if (sts.is_alpha || sts.is_dot) begin
								cmd.start_word = 1'b1;
							end
						end
					endcase
				end
			end
			ST_FLUSH: begin
				if (sts.slot_free) begin
					cmd.emit_flush = 1'b1;
					if (sts.flush_last) begin
						// the ending byte gets a second pass from idle, unless it is the end marker
						state_d = sts.is_eot ? ST_IDLE : ST_EXEC;
					end
				end
			end
			ST_SINGLE: begin
				if (sts.slot_free) begin
					cmd.emit_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (sts.mode != MODE_IDLE))
		else $error("flush with no lexeme pending");

endmodule
